// ----- rtl/core/sum_difference_prime_check_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the sum/difference prime checker
// Shared concurrent assertion forms, clocked on i_clk and gated by reset.
// ---------------------------------------------------------------------------
`ifndef SUM_DIFFERENCE_PRIME_CHECK_DEFINES_SVH
`define SUM_DIFFERENCE_PRIME_CHECK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDPC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sdpc_pkg.sv -----
// ---------------------------------------------------------------------------
// Sum/difference prime checker package
// Field widths, beat types, prime memory entry type and the elaboration-time
// functions that build the table of primes and their reciprocals.
// ---------------------------------------------------------------------------
package sdpc_pkg;

    localparam int VAL_W         = 14;
    localparam int IDX_W         = 14;
    localparam int SUM_W         = VAL_W + 1;
    localparam int PRIME_W       = 8;
    localparam int SQUARE_W      = 2 * PRIME_W;
    localparam int RECIP_SHIFT   = SUM_W + 9;
    localparam int RECIP_W       = RECIP_SHIFT;
    localparam int PRIME_TAB_N   = 64;
    localparam int TAB_AW        = $clog2(PRIME_TAB_N);
    localparam int PRIME_LIMIT_DEF = 150;

    typedef struct packed {
        logic [VAL_W-1:0] a_value;
        logic [VAL_W-1:0] b_value;
        logic [IDX_W-1:0] item_index;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] found_index;
        logic             is_difference;
    } t_out_item;

    typedef struct packed {
        logic [PRIME_W-1:0]  prime;
        logic [SQUARE_W-1:0] square;
        logic [RECIP_W-1:0]  recip;
    } t_entry;

    typedef t_entry [PRIME_TAB_N-1:0] t_entry_tab;

    // One table probe on its way into the divisibility check.
    typedef struct packed {
        logic   valid;
        logic   exhausted;
        t_entry entry;
    } t_probe;

    typedef struct packed {
        logic decided;
        logic prime;
    } t_verdict;

    function automatic int count_primes(int limit);
        logic [255:0] comp;
        int cnt;
        comp = '0;
        cnt  = 0;
        for (int i = 2; i < limit; i++) begin
            if (!comp[i]) begin
                cnt++;
                for (int j = i * i; j < limit; j += i) begin
                    comp[j] = 1'b1;
                end
            end
        end
        return cnt;
    endfunction

    // floor(2**RECIP_SHIFT / p) by restoring long division.
    function automatic logic [RECIP_W-1:0] recip_of(int p);
        logic [RECIP_SHIFT:0] num;
        logic [RECIP_SHIFT:0] quot;
        logic [PRIME_W:0]     rem;
        num  = '0;
        num[RECIP_SHIFT] = 1'b1;
        quot = '0;
        rem  = '0;
        for (int b = RECIP_SHIFT; b >= 0; b--) begin
            rem = {rem[PRIME_W-1:0], num[b]};
            if (rem >= (PRIME_W + 1)'(p)) begin
                rem     = rem - (PRIME_W + 1)'(p);
                quot[b] = 1'b1;
            end
        end
        return quot[RECIP_W-1:0];
    endfunction

    function automatic t_entry_tab entry_table(int limit);
        t_entry_tab tab;
        logic [255:0] comp;
        int cnt;
        tab  = '0;
        comp = '0;
        cnt  = 0;
        for (int i = 2; i < limit; i++) begin
            if (!comp[i]) begin
                tab[cnt].prime  = PRIME_W'(i);
                tab[cnt].square = SQUARE_W'(i * i);
                tab[cnt].recip  = recip_of(i);
                cnt++;
                for (int j = i * i; j < limit; j += i) begin
                    comp[j] = 1'b1;
                end
            end
        end
        return tab;
    endfunction

endpackage

// ----- rtl/core/sdpc_divcheck.sv -----
// ---------------------------------------------------------------------------
// Divisibility check
// Takes one prime table entry a cycle and decides whether trial division
// stops there: the value is prime once the prime's square exceeds it or the
// table runs out, and composite once the prime divides it.
// ---------------------------------------------------------------------------
module sdpc_divcheck
    import sdpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_probe           i_probe,
    input  logic [SUM_W-1:0] i_value,
    input  logic             i_flush,
    output t_verdict         o_verdict
);

    localparam int PROD_W = SUM_W + RECIP_W;
    localparam int QP_W   = SUM_W + PRIME_W;

    logic                r_valid;
    logic                r_exh;
    logic                r_sqgt;
    logic [PRIME_W-1:0]  r_prime;
    logic [PROD_W-1:0]   r_prod;

    logic [PROD_W-1:0]   w_prod;
    logic [SUM_W-1:0]    w_quot;
    logic [QP_W-1:0]     w_qp;
    logic [QP_W-1:0]     w_rem;
    logic                w_divides;

    assign w_prod = PROD_W'(i_value) * PROD_W'(i_probe.entry.recip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_probe.valid && !i_flush;
        end
        r_exh   <= i_probe.exhausted;
        r_sqgt  <= i_probe.entry.square > SQUARE_W'(i_value);
        r_prime <= i_probe.entry.prime;
        r_prod  <= w_prod;
    end

    // The reciprocal estimate is at most one below the true quotient, so the
    // remainder lands in [0, 2p) and divisibility shows as 0 or p.
    assign w_quot    = r_prod[PROD_W-1:RECIP_SHIFT];
    assign w_qp      = QP_W'(w_quot) * QP_W'(r_prime);
    assign w_rem     = QP_W'(i_value) - w_qp;
    assign w_divides = (w_rem == '0) || (w_rem == QP_W'(r_prime));

    assign o_verdict.decided = r_valid && (r_exh || r_sqgt || w_divides);
    assign o_verdict.prime   = r_exh || r_sqgt;

endmodule

// ----- rtl/core/sum_difference_prime_check.sv -----
// ---------------------------------------------------------------------------
// Sum/difference prime checker
// Tests a-b (when a exceeds b), then a+b, for primality by trial division over a memory of the
// primes below PRIME_LIMIT and reports the tag of the first prime found.
// ---------------------------------------------------------------------------
// Busy stays high while an item is tested and drops with the result strobe,
// or without one when neither value proves prime, so one item is in work at
// a time. Each test reads one prime memory entry per cycle into the
// reciprocal check of sdpc_divcheck, whose product is registered before the
// remainder is formed. Results cannot be stalled.
// After reset the prime memory is filled with busy high.
// ---------------------------------------------------------------------------
module sum_difference_prime_check
    import sdpc_pkg::*;
#(
    parameter int PRIME_LIMIT = PRIME_LIMIT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_result_valid,
    output t_out_item o_result
);

    `include "sum_difference_prime_check_defines.svh"

    localparam int PRIME_COUNT = count_primes(PRIME_LIMIT);
    localparam int AW = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;
    localparam int KW = $clog2(PRIME_COUNT + 1);
    localparam t_entry_tab ENTRY_TAB = entry_table(PRIME_LIMIT);
    localparam logic [KW-1:0] LAST_K    = KW'(PRIME_COUNT);
    localparam logic [AW-1:0] FILL_LAST = AW'(PRIME_COUNT - 1);

    localparam logic [1:0] ST_FILL = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_TEST = 2'd2;

    localparam logic PH_DIFF = 1'b1;
    localparam logic PH_SUM  = 1'b0;

    t_entry r_mem [PRIME_COUNT];
    t_entry r_rd;

    logic [1:0]       r_state, n_state;
    logic [AW-1:0]    r_fill, n_fill;
    logic [KW-1:0]    r_k, n_k;
    logic             r_issue_on, n_issue_on;
    logic             r_phase, n_phase;
    logic [SUM_W-1:0] r_value, n_value;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [IDX_W-1:0] r_tag, n_tag;
    logic             r_s1_valid, n_s1_valid;
    logic             r_s1_exh, n_s1_exh;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic [SUM_W-1:0] w_diff;
    logic [SUM_W-1:0] w_sum;
    logic             w_diff_ok;
    logic             w_issue;
    logic [AW-1:0]    w_addr;
    t_probe           w_probe;
    t_verdict         w_verdict;

    assign w_diff    = {1'b0, i_item.a_value} - {1'b0, i_item.b_value};
    assign w_sum     = {1'b0, i_item.a_value} + {1'b0, i_item.b_value};
    assign w_diff_ok = (i_item.a_value > i_item.b_value) && (w_diff > SUM_W'(1));
    assign w_issue   = (r_state == ST_TEST) && r_issue_on && !w_verdict.decided;
    // The probe past the last prime only marks the table as exhausted.
    assign w_addr    = (r_k >= LAST_K) ? '0 : r_k[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_k         = r_k;
        n_issue_on  = r_issue_on;
        n_phase     = r_phase;
        n_value     = r_value;
        n_sum       = r_sum;
        n_tag       = r_tag;
        n_out_valid = 1'b0;
        n_out       = r_out;
        n_s1_valid  = w_issue;
        n_s1_exh    = (r_k == LAST_K);
        case (r_state)
            ST_FILL: begin
                n_fill = r_fill + AW'(1);
                if (r_fill == FILL_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_k        = '0;
                n_issue_on = 1'b1;
                if (start) begin
                    n_tag = i_item.item_index;
                    n_sum = w_sum;
                    if (w_diff_ok) begin
                        n_phase = PH_DIFF;
                        n_value = w_diff;
                        n_state = ST_TEST;
                    end else if (w_sum >= SUM_W'(2)) begin
                        n_phase = PH_SUM;
                        n_value = w_sum;
                        n_state = ST_TEST;
                    end
                end
            end
            ST_TEST: begin
                if (w_issue) begin
                    n_k = r_k + KW'(1);
                    if (r_k == LAST_K) begin
                        n_issue_on = 1'b0;
                    end
                end
                if (w_verdict.decided) begin
                    n_k        = '0;
                    n_issue_on = 1'b1;
                    if (w_verdict.prime) begin
                        n_out_valid         = 1'b1;
                        n_out.found_index   = r_tag;
                        n_out.is_difference = (r_phase == PH_DIFF);
                        n_state             = ST_IDLE;
                    end else if ((r_phase == PH_DIFF) && (r_sum >= SUM_W'(2))) begin
                        n_phase = PH_SUM;
                        n_value = r_sum;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_fill      <= '0;
            r_k         <= '0;
            r_issue_on  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_k         <= n_k;
            r_issue_on  <= n_issue_on;
            r_s1_valid  <= n_s1_valid && !w_verdict.decided;
            r_out_valid <= n_out_valid;
        end
        r_phase  <= n_phase;
        r_value  <= n_value;
        r_sum    <= n_sum;
        r_tag    <= n_tag;
        r_s1_exh <= n_s1_exh;
        r_out    <= n_out;
    end

    // Prime memory: filled once after reset, then read one entry a cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FILL) begin
            r_mem[r_fill] <= ENTRY_TAB[TAB_AW'(r_fill)];
        end
        r_rd <= r_mem[w_addr];
    end

    assign w_probe.valid     = r_s1_valid;
    assign w_probe.exhausted = r_s1_exh;
    assign w_probe.entry     = r_rd;

    sdpc_divcheck u_divcheck (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_probe   (w_probe),
        .i_value   (r_value),
        .i_flush   (w_verdict.decided),
        .o_verdict (w_verdict)
    );

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    `SDPC_ASSERT_NXT(a_no_result_after_accept, start && !busy, !o_result_valid,
        "result beat straight after an accepted item")
    `SDPC_ASSERT_NXT(a_single_strobe, o_result_valid, !o_result_valid,
        "result beats on consecutive cycles")
    `SDPC_ASSERT_IMP(a_verdict_in_test, w_verdict.decided, r_state == ST_TEST,
        "trial division verdict outside the test state")
    `SDPC_ASSERT_IMP(a_no_result_in_fill, r_state == ST_FILL, !o_result_valid,
        "result beat while the prime memory is being filled")

endmodule
